@@ hw/rtl/cbe_pkg.sv @@
// Shared types, constants and helpers of the cubic B-spline evaluator.
`timescale 1ns / 1ps
package cbe_pkg;

    localparam int MAX_POINTS = 256;
    localparam int NUM_BANKS  = 4;
    localparam int BANK_DEPTH = MAX_POINTS / NUM_BANKS;
    localparam int NW         = 9;   // point count width
    localparam int KW         = 8;   // knot / index width
    localparam int XW         = 24;  // Q8.16 position
    localparam int CW         = 32;  // Q16.16 coefficient
    localparam int BW         = 26;  // Q.24 basis value
    localparam int OW         = 19;  // knot-to-position distance, Q.16
    localparam int DW         = 3;   // knot difference
    localparam int QW         = 28;  // dividend of the small divider
    localparam int RW         = 32;  // reciprocal
    localparam int PW         = QW + RW;
    localparam int RSH        = 31;  // reciprocal scale

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [NW-1:0] POINTS_RESET = NW'(MAX_POINTS);

    typedef struct packed {
        logic                 opcode;
        logic [KW-1:0]        coef_index;
        logic signed [CW-1:0] coef_value;
        logic [XW-1:0]        position;
    } t_in_word;

    typedef struct packed {
        logic signed [CW-1:0] spline_value;
        logic signed [CW-1:0] spline_slope;
        logic                 saturated;
    } t_out_word;

    typedef logic [BW-1:0] t_basis;
    typedef t_basis [2:0]  t_basis3;
    typedef t_basis [3:0]  t_basis4;
    typedef logic [OW-1:0] t_opnd;
    typedef t_opnd [2:0]   t_opnd3;
    typedef logic [DW-1:0] t_div;
    typedef t_div [2:0]    t_div3;

    // ceil(2^31 / d); exact floor division for dividends below 2^28
    function automatic logic [RW-1:0] recip(input t_div d);
        logic [RW-1:0] m;
        case (d)
            3'd1:    m = 32'h8000_0000;
            3'd2:    m = 32'h4000_0000;
            3'd3:    m = 32'h2AAA_AAAB;
            3'd4:    m = 32'h2000_0000;
            3'd5:    m = 32'h1999_999A;
            3'd6:    m = 32'h1555_5556;
            3'd7:    m = 32'h1249_2493;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

@@ hw/rtl/cbe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ hw/rtl/cbe_level.sv @@
// One Cox-de Boor recursion level: three lanes, three pipeline stages.
`timescale 1ns / 1ps
module cbe_level (
    input  logic             i_clk,
    input  logic             i_en,
    input  cbe_pkg::t_basis3 i_basis,
    input  cbe_pkg::t_opnd3  i_lft,
    input  cbe_pkg::t_opnd3  i_rgt,
    input  cbe_pkg::t_div3   i_div,
    output cbe_pkg::t_basis4 o_basis
);

    localparam int MW = cbe_pkg::OW + cbe_pkg::BW;

    logic [MW-1:0]          r_pa [3];
    logic [MW-1:0]          r_pb [3];
    cbe_pkg::t_div3         r_da;
    logic [cbe_pkg::PW-1:0] r_qa [3];
    logic [cbe_pkg::PW-1:0] r_qb [3];
    cbe_pkg::t_basis4       r_out;

    logic [cbe_pkg::PW-1:0] n_qa [3];
    logic [cbe_pkg::PW-1:0] n_qb [3];
    cbe_pkg::t_basis3       w_a;
    cbe_pkg::t_basis3       w_b;
    cbe_pkg::t_basis4       n_out;

    always_comb begin
        logic [MW:0]            sa;
        logic [MW:0]            sb;
        logic [MW:0]            half;
        logic [cbe_pkg::RW-1:0] m;
        for (int r = 0; r < 3; r++) begin
            half    = (MW+1)'(r_da[r]) << 15;
            sa      = (MW+1)'(r_pa[r]) + half;
            sb      = (MW+1)'(r_pb[r]) + half;
            m       = cbe_pkg::recip(r_da[r]);
            n_qa[r] = cbe_pkg::PW'(sa[16 +: cbe_pkg::QW]) * cbe_pkg::PW'(m);
            n_qb[r] = cbe_pkg::PW'(sb[16 +: cbe_pkg::QW]) * cbe_pkg::PW'(m);
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_a[r] = r_qa[r][cbe_pkg::RSH +: cbe_pkg::BW];
            w_b[r] = r_qb[r][cbe_pkg::RSH +: cbe_pkg::BW];
        end
        n_out[0] = w_a[0];
        n_out[1] = w_b[0] + w_a[1];
        n_out[2] = w_b[1] + w_a[2];
        n_out[3] = w_b[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_pa[r] <= MW'(i_rgt[r]) * MW'(i_basis[r]);
                r_pb[r] <= MW'(i_lft[r]) * MW'(i_basis[r]);
                r_qa[r] <= n_qa[r];
                r_qb[r] <= n_qb[r];
            end
            r_da  <= i_div;
            r_out <= n_out;
        end
    end

    assign o_basis = r_out;

endmodule

@@ hw/rtl/cubic_bspline_evaluator_core.sv @@
// Cubic B-spline evaluator: banked coefficient store and basis pipeline.
// Throughput: one word per cycle unless the receiver stalls the output; four
// coefficient banks serve the four-tap window. A write word produces no result.
// Synchronous active-low reset clears valids and sets the point count to 256;
// the coefficient store is not cleared.
`timescale 1ns / 1ps
module cubic_bspline_evaluator_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  cbe_pkg::t_in_word         i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output cbe_pkg::t_out_word        o_data,
    input  logic                      i_cfg_we,
    input  logic [cbe_pkg::NW-1:0]    i_cfg_wdata
);

    localparam int AW = $clog2(cbe_pkg::BANK_DEPTH);
    localparam int SW = 62;
    localparam int LAST = 12;

    typedef struct packed {
        logic [cbe_pkg::XW-1:0]                x;
        logic [5:0][cbe_pkg::KW-1:0]           knot;
        logic [1:0]                            base_lo;
        logic [3:0][cbe_pkg::CW-1:0]           coef;
    } t_side;

    typedef logic signed [26:0] t_slope;

    logic [cbe_pkg::NW-1:0] r_n;
    logic [LAST:0]          r_vld;
    cbe_pkg::t_in_word      r_in;
    t_side                  r_sd [1:10];
    logic [cbe_pkg::PW-1:0] r_dp [3];
    t_slope                 r_db [4];
    t_slope                 r_db2 [4];
    logic signed [58:0]     r_pv [4];
    logic signed [58:0]     r_ps [4];
    logic signed [SW-1:0]   r_sv;
    logic signed [SW-1:0]   r_ss;
    logic                   r_out_valid;
    cbe_pkg::t_out_word     r_out;

    logic                   en;
    logic [cbe_pkg::NW-1:0] n_eff;
    t_side                  n_sd1;
    t_side                  n_sd2;
    logic [cbe_pkg::KW-1:0] base;
    logic [cbe_pkg::CW-1:0] rd [cbe_pkg::NUM_BANKS];
    logic [AW-1:0]          raddr [cbe_pkg::NUM_BANKS];
    logic                   ram_we;
    cbe_pkg::t_basis4       l1_out;
    cbe_pkg::t_basis4       l2_out;
    cbe_pkg::t_basis4       l3_out;
    cbe_pkg::t_basis3       l1_in;
    cbe_pkg::t_opnd3        l1_lft, l1_rgt, l2_lft, l2_rgt, l3_lft, l3_rgt;
    cbe_pkg::t_div3         l1_div, l2_div, l3_div;
    logic [cbe_pkg::PW-1:0] n_dp [3];
    t_slope                 n_db [4];
    logic signed [SW-1:0]   n_sv, n_ss;
    cbe_pkg::t_out_word     n_out;

    assign en      = !(r_out_valid && !i_ready && r_vld[LAST]);
    assign o_ready = en;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    function automatic logic [cbe_pkg::KW-1:0] knot_at(
        input logic [9:0] idx, input logic [cbe_pkg::NW-1:0] n);
        logic [cbe_pkg::KW-1:0] k;
        if (idx <= 10'd3) begin
            k = '0;
        end else if (idx < 10'(n)) begin
            k = cbe_pkg::KW'(idx - 10'd2);
        end else begin
            k = cbe_pkg::KW'(n - 9'd1);
        end
        return k;
    endfunction

    function automatic cbe_pkg::t_opnd3 f_rgt(input t_side s);
        cbe_pkg::t_opnd3 o;
        for (int r = 0; r < 3; r++) begin
            o[r] = cbe_pkg::OW'({s.knot[r+3], 16'b0} - s.x);
        end
        return o;
    endfunction

    function automatic cbe_pkg::t_opnd3 f_lft(input t_side s, input int j);
        cbe_pkg::t_opnd3 o;
        for (int r = 0; r < 3; r++) begin
            o[r] = cbe_pkg::OW'(s.x - {s.knot[3-j+r], 16'b0});
        end
        return o;
    endfunction

    function automatic cbe_pkg::t_div3 f_div(input t_side s, input int j);
        cbe_pkg::t_div3 o;
        for (int r = 0; r < 3; r++) begin
            o[r] = cbe_pkg::DW'(s.knot[r+3] - s.knot[r+3-j]);
        end
        return o;
    endfunction

    function automatic logic [cbe_pkg::CW:0] finish(input logic signed [SW-1:0] s);
        logic signed [SW:0]   t;
        logic signed [38:0]   q;
        logic [cbe_pkg::CW:0] o;
        t = (SW+1)'(s) + (SW+1)'(64'sd8388608);
        q = t[SW:24];
        if (q > 39'sd2147483647) begin
            o = {1'b1, 32'h7FFF_FFFF};
        end else if (q < -39'sd2147483648) begin
            o = {1'b1, 32'h8000_0000};
        end else begin
            o = {1'b0, q[31:0]};
        end
        return o;
    endfunction

    // interval search and bank addressing
    always_comb begin
        logic [cbe_pkg::XW-1:0] xmax;
        logic [cbe_pkg::NW-1:0] fl;
        logic [cbe_pkg::NW-1:0] iv;
        if (r_n < 9'd4) begin
            n_eff = 9'd4;
        end else if (r_n > cbe_pkg::POINTS_RESET) begin
            n_eff = cbe_pkg::POINTS_RESET;
        end else begin
            n_eff = r_n;
        end
        xmax    = {cbe_pkg::KW'(n_eff - 9'd1), 16'b0};
        n_sd1   = '0;
        n_sd1.x = (r_in.position > xmax) ? xmax : r_in.position;
        fl      = cbe_pkg::NW'(n_sd1.x[23:16]) + 9'd2;
        iv      = (fl < n_eff - 9'd1) ? fl : n_eff - 9'd1;
        if (iv < 9'd3) begin
            iv = 9'd3;
        end
        for (int i = 0; i < 6; i++) begin
            n_sd1.knot[i] = knot_at(10'(iv) - 10'd2 + 10'(i), n_eff);
        end
        base          = cbe_pkg::KW'(iv - 9'd3);
        n_sd1.base_lo = base[1:0];
    end

    assign ram_we = en && r_vld[0] && (r_in.opcode == cbe_pkg::OP_WRITE);

    for (genvar b = 0; b < cbe_pkg::NUM_BANKS; b++) begin : g_bank
        logic [1:0]             off;
        logic [cbe_pkg::KW-1:0] a;
        assign off      = 2'(b) - base[1:0];
        assign a        = base + cbe_pkg::KW'(off);
        assign raddr[b] = a[cbe_pkg::KW-1:2];
        cbe_ram #(
            .WIDTH (cbe_pkg::CW),
            .DEPTH (cbe_pkg::BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (ram_we && (r_in.coef_index[1:0] == 2'(b))),
            .i_waddr (r_in.coef_index[cbe_pkg::KW-1:2]),
            .i_wdata (r_in.coef_value),
            .i_re    (en),
            .i_raddr (raddr[b]),
            .o_rdata (rd[b])
        );
    end

    // rotate bank outputs into window order
    always_comb begin
        n_sd2 = r_sd[1];
        for (int j = 0; j < 4; j++) begin
            n_sd2.coef[j] = rd[2'(r_sd[1].base_lo + 2'(j))];
        end
    end

    assign l1_in  = {cbe_pkg::BW'(0), cbe_pkg::BW'(0), cbe_pkg::BW'(1 << 24)};
    assign l1_lft = f_lft(r_sd[1], 1);
    assign l1_rgt = f_rgt(r_sd[1]);
    assign l1_div = f_div(r_sd[1], 1);
    assign l2_lft = f_lft(r_sd[4], 2);
    assign l2_rgt = f_rgt(r_sd[4]);
    assign l2_div = f_div(r_sd[4], 2);
    assign l3_lft = f_lft(r_sd[7], 3);
    assign l3_rgt = f_rgt(r_sd[7]);
    assign l3_div = f_div(r_sd[7], 3);

    cbe_level u_l1 (
        .i_clk (i_clk), .i_en (en), .i_basis (l1_in),
        .i_lft (l1_lft), .i_rgt (l1_rgt), .i_div (l1_div), .o_basis (l1_out)
    );

    cbe_level u_l2 (
        .i_clk (i_clk), .i_en (en), .i_basis (l1_out[2:0]),
        .i_lft (l2_lft), .i_rgt (l2_rgt), .i_div (l2_div), .o_basis (l2_out)
    );

    cbe_level u_l3 (
        .i_clk (i_clk), .i_en (en), .i_basis (l2_out[2:0]),
        .i_lft (l3_lft), .i_rgt (l3_rgt), .i_div (l3_div), .o_basis (l3_out)
    );

    // derivative weights from the quadratic basis
    always_comb begin
        cbe_pkg::t_div          d;
        logic [cbe_pkg::QW-1:0] num;
        logic [cbe_pkg::BW-1:0] t [3];
        for (int j = 0; j < 3; j++) begin
            d       = cbe_pkg::DW'(r_sd[7].knot[j+3] - r_sd[7].knot[j]);
            num     = cbe_pkg::QW'(l2_out[j]) * 28'd3 + cbe_pkg::QW'(d >> 1);
            n_dp[j] = cbe_pkg::PW'(num) * cbe_pkg::PW'(cbe_pkg::recip(d));
        end
        for (int j = 0; j < 3; j++) begin
            t[j] = r_dp[j][cbe_pkg::RSH +: cbe_pkg::BW];
        end
        n_db[0] = -$signed({1'b0, t[0]});
        n_db[1] = $signed({1'b0, t[0]}) - $signed({1'b0, t[1]});
        n_db[2] = $signed({1'b0, t[1]}) - $signed({1'b0, t[2]});
        n_db[3] = $signed({1'b0, t[2]});
    end

    always_comb begin
        n_sv = '0;
        n_ss = '0;
        for (int j = 0; j < 4; j++) begin
            n_sv = n_sv + SW'(r_pv[j]);
            n_ss = n_ss + SW'(r_ps[j]);
        end
    end

    always_comb begin
        logic [cbe_pkg::CW:0] fv;
        logic [cbe_pkg::CW:0] fs;
        fv                 = finish(r_sv);
        fs                 = finish(r_ss);
        n_out.spline_value = fv[cbe_pkg::CW-1:0];
        n_out.spline_slope = fs[cbe_pkg::CW-1:0];
        n_out.saturated    = fv[cbe_pkg::CW] | fs[cbe_pkg::CW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= cbe_pkg::POINTS_RESET;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_n <= i_cfg_wdata;
            end
            if (en) begin
                r_vld[0] <= i_valid;
                r_vld[1] <= r_vld[0] && (r_in.opcode == cbe_pkg::OP_EVAL);
                r_vld[LAST:2] <= r_vld[LAST-1:1];
            end
            if (!r_out_valid || i_ready) begin
                r_out_valid <= r_vld[LAST];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in  <= i_data;
            r_sd[1] <= n_sd1;
            r_sd[2] <= n_sd2;
            for (int s = 3; s <= 10; s++) begin
                r_sd[s] <= r_sd[s-1];
            end
            for (int j = 0; j < 3; j++) begin
                r_dp[j] <= n_dp[j];
            end
            for (int j = 0; j < 4; j++) begin
                r_db[j]  <= n_db[j];
                r_db2[j] <= r_db[j];
                r_pv[j]  <= $signed(r_sd[10].coef[j]) * $signed({1'b0, l3_out[j]});
                r_ps[j]  <= $signed(r_sd[10].coef[j]) * r_db2[j];
            end
            r_sv <= n_sv;
            r_ss <= n_ss;
        end
        if (!r_out_valid || i_ready) begin
            r_out <= n_out;
        end
    end

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && r_vld[LAST]) |=> (r_vld[LAST] && $stable(r_sv)))
        else $error("pipeline moved while stalled");

    a_no_write_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> !ram_we)
        else $error("coefficient write during stall");

    a_pos_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_sd[1].x <= {cbe_pkg::KW'(n_eff - 9'd1), 16'b0}))
        else $error("position beyond grid");

    a_partition: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[10] |-> ((28'(l3_out[0]) + 28'(l3_out[1]) + 28'(l3_out[2])
            + 28'(l3_out[3]) <= 28'd16777232) && (28'(l3_out[0]) + 28'(l3_out[1])
            + 28'(l3_out[2]) + 28'(l3_out[3]) >= 28'd16777200)))
        else $error("basis does not sum to one");

endmodule

@@ dv/cubic_bspline_evaluator_core_test.sv @@
// Testbench for the cubic B-spline evaluator: directed table, random traffic, bit-exact predictor.
`timescale 1ns / 1ps
module cubic_bspline_evaluator_core_test;

    typedef longint unsigned t_u4 [4];
    typedef longint signed   t_s4 [4];

    typedef struct {
        logic                   op;
        logic [cbe_pkg::KW-1:0] idx;
        logic [cbe_pkg::CW-1:0] val;
        logic [cbe_pkg::XW-1:0] pos;
        bit                     typed;
        cbe_pkg::t_out_word     res;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    cbe_pkg::t_in_word   i_data;
    logic       o_valid;
    logic       i_ready;
    cbe_pkg::t_out_word  o_data;
    logic       i_cfg_we;
    logic [cbe_pkg::NW-1:0] i_cfg_wdata;

    longint signed coef_mem [cbe_pkg::MAX_POINTS];
    logic [cbe_pkg::NW-1:0] point_count;
    cbe_pkg::t_out_word     pending_results [$];
    int            mismatches;
    int            ready_hold;

    cubic_bspline_evaluator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("cubic_bspline_evaluator_core test failed");
        $finish;
    end

    function automatic int unsigned knot(int unsigned i, int unsigned n);
        if (i <= 3) return 0;
        if (i < n) return i - 2;
        return n - 1;
    endfunction

    function automatic t_u4 basis(longint unsigned x, int unsigned iv, int unsigned n, int lvl);
        t_u4 nb;
        t_u4 lft;
        t_u4 rgt;
        longint unsigned carry, a, b, d;
        nb = '{default: 0};
        lft = '{default: 0};
        rgt = '{default: 0};
        nb[0] = 64'd1 << 24;
        for (int j = 1; j <= lvl; j++) begin
            carry = 0;
            lft[j] = x - (longint'(knot(iv + 1 - j, n)) << 16);
            rgt[j] = (longint'(knot(iv + j, n)) << 16) - x;
            for (int r = 0; r < j; r++) begin
                d = knot(iv + r + 1, n) - knot(iv + 1 - j + r, n);
                a = 0;
                b = 0;
                if (d != 0) begin
                    a = (rgt[r+1] * nb[r] + (d << 15)) / (d << 16);
                    b = (lft[j-r] * nb[r] + (d << 15)) / (d << 16);
                end
                nb[r] = carry + a;
                carry = b;
            end
            nb[j] = carry;
        end
        return nb;
    endfunction

    function automatic logic [cbe_pkg::CW-1:0] round_sat(longint signed s, inout logic sat);
        longint signed q;
        q = (s + (64'sd1 <<< 23)) >>> 24;
        if (q > 64'sd2147483647) begin
            sat = 1'b1;
            q = 64'sd2147483647;
        end
        if (q < -64'sd2147483648) begin
            sat = 1'b1;
            q = -64'sd2147483648;
        end
        return q[cbe_pkg::CW-1:0];
    endfunction

    function automatic cbe_pkg::t_out_word spline_at(logic [cbe_pkg::XW-1:0] pos);
        int unsigned n, iv, m, d;
        longint unsigned x;
        t_u4 b, lo;
        t_s4 db;
        longint signed t, sv, ss;
        logic sat;
        cbe_pkg::t_out_word r;
        n = point_count;
        if (n < 4) n = 4;
        if (n > cbe_pkg::MAX_POINTS) n = cbe_pkg::MAX_POINTS;
        x = pos;
        if (x > (longint'(n - 1) << 16)) x = longint'(n - 1) << 16;
        iv = int'(x >> 16) + 2;
        if (iv > n - 1) iv = n - 1;
        if (iv < 3) iv = 3;
        b = basis(x, iv, n, 3);
        lo = basis(x, iv, n, 2);
        db = '{default: 0};
        for (int j = 0; j < 3; j++) begin
            m = iv - 2 + j;
            d = knot(m + 3, n) - knot(m, n);
            if (d != 0) begin
                t = longint'((3 * lo[j] + d / 2) / d);
                db[j] -= t;
                db[j+1] += t;
            end
        end
        sv = 0;
        ss = 0;
        for (int j = 0; j < 4; j++) begin
            sv += coef_mem[iv - 3 + j] * longint'(b[j]);
            ss += coef_mem[iv - 3 + j] * db[j];
        end
        sat = 1'b0;
        r.spline_value = round_sat(sv, sat);
        r.spline_slope = round_sat(ss, sat);
        r.saturated = sat;
        return r;
    endfunction

    // caller sits at a rising edge; returns at the edge that accepts the word
    task automatic send_word(logic op, logic [cbe_pkg::KW-1:0] idx,
                             logic [cbe_pkg::CW-1:0] val, logic [cbe_pkg::XW-1:0] pos,
                             bit typed, cbe_pkg::t_out_word res);
        int gap;
        int r;
        cbe_pkg::t_in_word w;
        r = $urandom_range(0, 19);
        gap = (r < 12) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w.opcode = op;
        w.coef_index = idx;
        w.coef_value = val;
        w.position = pos;
        i_valid <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (op == cbe_pkg::OP_WRITE) coef_mem[idx] = longint'(signed'(val));
        else pending_results.push_back(typed ? res : spline_at(pos));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_points(logic [cbe_pkg::NW-1:0] n);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        point_count = n;
        @(posedge i_clk);
    endtask

    function automatic logic [cbe_pkg::CW-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return cbe_pkg::CW'($signed($urandom_range(0, 32'h0010_0000))
                                         - 32'sh0008_0000);
        endcase
    endfunction

    function automatic logic [cbe_pkg::XW-1:0] rand_pos();
        int unsigned n;
        n = (point_count < 4) ? 4 : (point_count > cbe_pkg::MAX_POINTS) ?
            cbe_pkg::MAX_POINTS : point_count;
        case ($urandom_range(0, 9))
            0: return cbe_pkg::XW'($urandom());
            1: return cbe_pkg::XW'((n - 1) << 16);
            2: return cbe_pkg::XW'($urandom_range(0, 3) << 16);
            default: return cbe_pkg::XW'($urandom_range(0, ((n - 1) << 16) + 16'hFFFF));
        endcase
    endfunction

    // receiver stalls: mostly short, a few long, with open stretches in between
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            i_ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 9) < 2) begin
            i_ready <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", o_data);
            end else begin
                cbe_pkg::t_out_word e;
                e = pending_results.pop_front();
                if (o_data !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h %b, got %h %h %b",
                                 e.spline_value, e.spline_slope, e.saturated,
                                 o_data.spline_value, o_data.spline_slope, o_data.saturated);
                end
            end
        end
    end

    t_row directed [] = '{
        '{cbe_pkg::OP_EVAL,  8'd0,   32'h0000_0000, 24'h00_0000, 1'b1, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_EVAL,  8'd0,   32'h0000_0000, 24'hFF_FFFF, 1'b1, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_EVAL,  8'd0,   32'h0000_0000, 24'h7F_8000, 1'b1, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_WRITE, 8'd0,   32'h7FFF_FFFF, 24'h00_0000, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_WRITE, 8'd1,   32'h8000_0000, 24'hFF_FFFF, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_WRITE, 8'd2,   32'h7FFF_FFFF, 24'h00_0000, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_WRITE, 8'd3,   32'h8000_0000, 24'h00_0000, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_EVAL,  8'd0,   32'h0000_0000, 24'h00_0000, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_EVAL,  8'd0,   32'h0000_0000, 24'h00_8000, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_EVAL,  8'd0,   32'h0000_0000, 24'h01_0000, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_EVAL,  8'd0,   32'h0000_0000, 24'h01_FFFF, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_WRITE, 8'd255, 32'h7FFF_FFFF, 24'h00_0000, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_WRITE, 8'd254, 32'h8000_0000, 24'h00_0000, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_WRITE, 8'd253, 32'h0001_0000, 24'h00_0000, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_EVAL,  8'd0,   32'h0000_0000, 24'hFF_FFFF, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_EVAL,  8'd0,   32'h0000_0000, 24'hFF_0000, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_EVAL,  8'd0,   32'h0000_0000, 24'hFE_8000, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_EVAL,  8'd0,   32'h0000_0000, 24'hFC_C000, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_WRITE, 8'd128, 32'h0001_0000, 24'h00_0000, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_EVAL,  8'd0,   32'h0000_0000, 24'h7E_0000, 1'b0, '{32'd0, 32'd0, 1'b0}},
        '{cbe_pkg::OP_EVAL,  8'd0,   32'h0000_0000, 24'h7E_4000, 1'b0, '{32'd0, 32'd0, 1'b0}}
    };

    logic [cbe_pkg::NW-1:0] point_phases [] =
        '{9'd4, 9'd5, 9'd0, 9'd7, 9'd37, 9'd511, 9'd255, 9'd256};

    initial begin
        cbe_pkg::t_out_word none;
        none = '0;
        mismatches = 0;
        point_count = cbe_pkg::POINTS_RESET;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // the store is not cleared by reset: fill every slot before any read
        for (int k = 0; k < cbe_pkg::MAX_POINTS; k++)
            send_word(cbe_pkg::OP_WRITE, cbe_pkg::KW'(k), '0, cbe_pkg::XW'($urandom()),
                      1'b0, none);
        foreach (directed[k])
            send_word(directed[k].op, directed[k].idx, directed[k].val, directed[k].pos,
                      directed[k].typed, directed[k].res);
        drain();

        foreach (point_phases[p]) begin
            set_points(point_phases[p]);
            for (int k = 0; k < 155; k++) begin
                if ($urandom_range(0, 99) < 15)
                    send_word(cbe_pkg::OP_WRITE, cbe_pkg::KW'($urandom()), rand_coef(),
                              cbe_pkg::XW'($urandom()), 1'b0, none);
                else
                    send_word(cbe_pkg::OP_EVAL, cbe_pkg::KW'($urandom()), $urandom(),
                              rand_pos(), 1'b0, none);
            end
            drain();
        end

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("cubic_bspline_evaluator_core test passed");
        end else begin
            $display("cubic_bspline_evaluator_core test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/cbe_pkg.sv
hw/rtl/cbe_ram.sv
hw/rtl/cbe_level.sv
hw/rtl/cubic_bspline_evaluator_core.sv
dv/cubic_bspline_evaluator_core_test.sv
